/* hw/rtl/cpr_pkg.sv */
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types and constants of the audio chunk packetizer: defaults for
// chunk length and ring depth, header bytes, request codes, result flags.
// ----------------------------------------------------------------------------
package cpr_pkg;

    localparam int SAMPLES_PER_CHUNK_DEF = 512;
    localparam int RING_DEPTH_DEF        = 16;

    localparam logic [7:0] HDR_BYTE0 = 8'hAD;
    localparam logic [7:0] HDR_BYTE1 = 8'h10;

    typedef enum logic [0:0] {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } t_req_type;

    // status of one finished item, shown for one cycle
    typedef struct packed {
        logic done;
        logic word_valid;
        logic hdr_sel;
        logic last_word;
        logic committed;
        logic dropped;
    } t_cpr_flags;

endpackage

/* hw/rtl/cpr_sample_mem.sv */
// ----------------------------------------------------------------------------
// cpr_sample_mem
// Single-port sample store: one write or one read per cycle, registered
// read data.
// ----------------------------------------------------------------------------
module cpr_sample_mem #(
    parameter int DEPTH = 8704,
    parameter int AW    = 14
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [31:0]   i_wdata,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    // write or read one word
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/cpr_ring_ctrl.sv */
// ----------------------------------------------------------------------------
// cpr_ring_ctrl
// Ring pointers, fill and drop counters. Samples go straight into the slot
// being filled; one spare slot keeps that slot apart from every live packet.
// ----------------------------------------------------------------------------
module cpr_ring_ctrl
    import cpr_pkg::*;
#(
    parameter int SAMPLES_PER_CHUNK = SAMPLES_PER_CHUNK_DEF,
    parameter int RING_DEPTH        = RING_DEPTH_DEF,
    parameter int FW                = $clog2(RING_DEPTH + 1),
    parameter int AW                = $clog2((RING_DEPTH + 1) * SAMPLES_PER_CHUNK)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_req_type,
    input  logic [15:0]   i_left_sample,
    input  logic [15:0]   i_right_sample,
    input  logic          i_enable,
    output logic          o_mem_en,
    output logic          o_mem_we,
    output logic [AW-1:0] o_mem_addr,
    output logic [31:0]   o_mem_wdata,
    output t_cpr_flags    o_flags,
    output logic [15:0]   o_hdr_seq,
    output logic [FW-1:0] o_ring_fill,
    output logic [31:0]   o_drop_total
);

    localparam int NSLOT = RING_DEPTH + 1;
    localparam int PW    = (SAMPLES_PER_CHUNK > 1) ? $clog2(SAMPLES_PER_CHUNK) : 1;
    localparam int RW    = $clog2(SAMPLES_PER_CHUNK + 1);
    localparam logic [AW-1:0] LAST_BASE  = AW'((NSLOT - 1) * SAMPLES_PER_CHUNK);
    localparam logic [AW-1:0] SLOT_WORDS = AW'(SAMPLES_PER_CHUNK);

    logic [PW-1:0] r_pos,   n_pos;
    logic [RW-1:0] r_roff,  n_roff;
    logic [AW-1:0] r_wbase, n_wbase;
    logic [AW-1:0] r_rbase, n_rbase;
    logic [FW-1:0] r_fill,  n_fill;
    logic [15:0]   r_seq,   n_seq;
    logic [31:0]   r_drops, n_drops;
    t_cpr_flags    r_flags, n_flags;
    logic [15:0]   r_hdr_seq, n_hdr_seq;

    // next slot base, wrapping over the physical slots
    function automatic logic [AW-1:0] base_next(input logic [AW-1:0] base);
        return (base == LAST_BASE) ? '0 : base + SLOT_WORDS;
    endfunction

    // update ring state and issue the memory access for one item
    always_comb begin
        n_pos       = r_pos;
        n_roff      = r_roff;
        n_wbase     = r_wbase;
        n_rbase     = r_rbase;
        n_fill      = r_fill;
        n_seq       = r_seq;
        n_drops     = r_drops;
        n_flags     = '0;
        n_hdr_seq   = r_hdr_seq;
        o_mem_en    = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_addr  = r_wbase + AW'(r_pos);
        o_mem_wdata = {i_right_sample, i_left_sample};
        if (i_start) begin
            n_flags.done = 1'b1;
            if (t_req_type'(i_req_type) == REQ_PUSH) begin
                if (i_enable) begin
                    o_mem_en = 1'b1;
                    o_mem_we = 1'b1;
                    if (r_pos == PW'(SAMPLES_PER_CHUNK - 1)) begin
                        // commit the chunk, dropping the oldest packet when full
                        n_flags.committed = 1'b1;
                        n_pos   = '0;
                        n_wbase = base_next(r_wbase);
                        n_seq   = r_seq + 16'd1;
                        if (r_fill == FW'(RING_DEPTH)) begin
                            n_flags.dropped = 1'b1;
                            n_rbase = base_next(r_rbase);
                            n_roff  = '0;
                            if (r_drops != '1) begin
                                n_drops = r_drops + 32'd1;
                            end
                        end else begin
                            n_fill = r_fill + FW'(1);
                        end
                    end else begin
                        n_pos = r_pos + PW'(1);
                    end
                end
            end else if (r_fill != '0) begin
                n_flags.word_valid = 1'b1;
                if (r_roff == '0) begin
                    // header carries the oldest packet's sequence number
                    n_flags.hdr_sel = 1'b1;
                    n_hdr_seq = r_seq - 16'(r_fill);
                end else begin
                    o_mem_en   = 1'b1;
                    o_mem_addr = r_rbase + AW'(r_roff) - AW'(1);
                end
                if (r_roff == RW'(SAMPLES_PER_CHUNK)) begin
                    // last word frees the slot
                    n_flags.last_word = 1'b1;
                    n_roff  = '0;
                    n_rbase = base_next(r_rbase);
                    n_fill  = r_fill - FW'(1);
                end else begin
                    n_roff = r_roff + RW'(1);
                end
            end
        end
    end

    // hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_roff  <= '0;
            r_wbase <= '0;
            r_rbase <= '0;
            r_fill  <= '0;
            r_seq   <= '0;
            r_drops <= '0;
            r_flags <= '0;
        end else begin
            r_pos   <= n_pos;
            r_roff  <= n_roff;
            r_wbase <= n_wbase;
            r_rbase <= n_rbase;
            r_fill  <= n_fill;
            r_seq   <= n_seq;
            r_drops <= n_drops;
            r_flags <= n_flags;
        end
    end

    // header payload
    always_ff @(posedge i_clk) begin
        r_hdr_seq <= n_hdr_seq;
    end

    assign o_flags      = r_flags;
    assign o_hdr_seq    = r_hdr_seq;
    assign o_ring_fill  = r_fill;
    assign o_drop_total = r_drops;

endmodule

/* hw/rtl/pcm_chunk_packetizer_ring_top.sv */
// ----------------------------------------------------------------------------
// pcm_chunk_packetizer_ring_top
// Audio packetizer: gathers stereo samples into chunks, keeps a drop-oldest
// ring of packets and reads them out one word per pop.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: raise start with i_req_type and the samples; the item is
//   taken at that edge (busy stays low). A push stores one stereo word, a
//   pop reads one word of the oldest packet.
//   Result channel: o_done is high for one cycle, the cycle right after the
//   item was taken, with every result field valid. One item can be taken
//   every cycle; a push costs at most one write and a pop at most one
//   read of the single-port sample memory. The receiver cannot stall, so a
//   result is lost if it is not taken in that cycle.
//   Configuration: i_cfg_valid writes stream_enable from i_cfg_data; the
//   port is always ready. Write it only while no item is in flight.
//   Reset: all counters and the ring clear at once, stream_enable goes low;
//   there is no clearing pass over the sample memory. The memory holds one
//   spare slot beyond the ring depth for the chunk being gathered.
// ----------------------------------------------------------------------------
module pcm_chunk_packetizer_ring_top
    import cpr_pkg::*;
#(
    parameter int SAMPLES_PER_CHUNK = SAMPLES_PER_CHUNK_DEF,
    parameter int RING_DEPTH        = RING_DEPTH_DEF,
    parameter int FW                = $clog2(RING_DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic          i_req_type,
    input  logic [15:0]   i_left_sample,
    input  logic [15:0]   i_right_sample,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data,
    output logic          o_done,
    output logic [31:0]   o_data_word,
    output logic          o_word_valid,
    output logic          o_last_word,
    output logic          o_chunk_committed,
    output logic          o_chunk_dropped,
    output logic [FW-1:0] o_ring_fill,
    output logic [31:0]   o_dropped_total
);

    localparam int DEPTH = (RING_DEPTH + 1) * SAMPLES_PER_CHUNK;
    localparam int AW    = $clog2(DEPTH);

    logic          r_stream_enable;
    logic          mem_en;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0]   mem_wdata;
    logic [31:0]   mem_rdata;
    t_cpr_flags    flags;
    logic [15:0]   hdr_seq;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_enable <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_stream_enable <= i_cfg_data;
        end
    end

    cpr_ring_ctrl #(
        .SAMPLES_PER_CHUNK (SAMPLES_PER_CHUNK),
        .RING_DEPTH        (RING_DEPTH),
        .FW                (FW),
        .AW                (AW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start && !busy),
        .i_req_type     (i_req_type),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_enable       (r_stream_enable),
        .o_mem_en       (mem_en),
        .o_mem_we       (mem_we),
        .o_mem_addr     (mem_addr),
        .o_mem_wdata    (mem_wdata),
        .o_flags        (flags),
        .o_hdr_seq      (hdr_seq),
        .o_ring_fill    (o_ring_fill),
        .o_drop_total   (o_dropped_total)
    );

    cpr_sample_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // select header or sample word, zero when nothing was read
    always_comb begin
        if (!flags.word_valid) begin
            o_data_word = '0;
        end else if (flags.hdr_sel) begin
            o_data_word = {hdr_seq[7:0], hdr_seq[15:8], HDR_BYTE1, HDR_BYTE0};
        end else begin
            o_data_word = mem_rdata;
        end
    end

    assign o_done            = flags.done;
    assign o_word_valid      = flags.word_valid;
    assign o_last_word       = flags.last_word;
    assign o_chunk_committed = flags.committed;
    assign o_chunk_dropped   = flags.dropped;

endmodule

/* bench/pcm_packet_checker.sv */
// ----------------------------------------------------------------------------
// pcm_packet_checker
// Watches the request, result and stream-enable channels of the audio
// packetizer. Keeps its own copy of the chunk gatherer and packet ring,
// predicts the result word of every accepted request and compares it field
// by field against what the block returns.
// ----------------------------------------------------------------------------
module pcm_packet_checker
    import cpr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        i_req_type,
    input  logic [15:0] i_left_sample,
    input  logic [15:0] i_right_sample,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic        i_cfg_data,
    input  logic        o_done,
    input  logic [31:0] o_data_word,
    input  logic        o_word_valid,
    input  logic        o_last_word,
    input  logic        o_chunk_committed,
    input  logic        o_chunk_dropped,
    input  logic [4:0]  o_ring_fill,
    input  logic [31:0] o_dropped_total,
    output int          o_pending_words,
    output int          o_mismatch_count
);

    localparam int CHUNK            = SAMPLES_PER_CHUNK_DEF;
    localparam int RING             = RING_DEPTH_DEF;
    localparam int SHOWN_MISMATCHES = 40;

    typedef struct packed {
        logic [31:0] data_word;
        logic        word_valid;
        logic        last_word;
        logic        committed;
        logic        dropped;
        logic [4:0]  ring_fill;
        logic [31:0] dropped_total;
    } t_packet_word;

    // results predicted but not yet returned, oldest first
    t_packet_word expected_words[$];

    // shadow of the packetizer state
    logic        stream_on;
    logic [31:0] chunk_buf [CHUNK];
    int          fill_pos;
    logic [15:0] seq_next;
    logic [31:0] ring_store [RING*CHUNK];
    logic [15:0] ring_seq [RING];
    int          wr_cnt;
    int          rd_cnt;
    int          rd_word;
    logic [31:0] drop_total;

    // slot counters run modulo twice the depth so full and empty differ
    function automatic int bump(input int cnt);
        return (cnt + 1) % (2 * RING);
    endfunction

    function automatic int ring_level();
        return (wr_cnt - rd_cnt + 2 * RING) % (2 * RING);
    endfunction

    // Apply one request to the shadow state and return the word it yields.
    function automatic t_packet_word next_packet_word(input t_req_type kind,
                                                      input logic [15:0] left,
                                                      input logic [15:0] right);
        t_packet_word res;
        int           slot;
        int           i;
        res = '0;
        if (kind == REQ_PUSH) begin
            if (stream_on) begin
                chunk_buf[fill_pos] = {right, left};
                fill_pos++;
                if (fill_pos == CHUNK) begin
                    // ring full: drop the oldest packet, restart any read in progress
                    if (ring_level() == RING) begin
                        rd_cnt  = bump(rd_cnt);
                        rd_word = 0;
                        if (drop_total != 32'hFFFF_FFFF) drop_total++;
                        res.dropped = 1'b1;
                    end
                    slot = wr_cnt % RING;
                    for (i = 0; i < CHUNK; i++) ring_store[slot * CHUNK + i] = chunk_buf[i];
                    ring_seq[slot] = seq_next;
                    wr_cnt         = bump(wr_cnt);
                    seq_next++;
                    fill_pos       = 0;
                    res.committed  = 1'b1;
                end
            end
        end else if (ring_level() != 0) begin
            slot = rd_cnt % RING;
            if (rd_word == 0) begin
                res.data_word = {ring_seq[slot][7:0], ring_seq[slot][15:8],
                                 HDR_BYTE1, HDR_BYTE0};
            end else begin
                res.data_word = ring_store[slot * CHUNK + rd_word - 1];
            end
            res.word_valid = 1'b1;
            if (rd_word == CHUNK) begin
                res.last_word = 1'b1;
                rd_cnt        = bump(rd_cnt);
                rd_word       = 0;
            end else begin
                rd_word++;
            end
        end
        res.ring_fill     = 5'(ring_level());
        res.dropped_total = drop_total;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            o_mismatch_count++;
            if (o_mismatch_count <= SHOWN_MISMATCHES) begin
                $error("%s mismatch: expected %h, got %h", name, want, got);
            end
        end
    endfunction

    // Compare the returned word first, then take config and new requests.
    always @(posedge i_clk) begin
        t_packet_word want;
        if (!i_rst_n) begin
            stream_on  = 1'b0;
            fill_pos   = 0;
            seq_next   = '0;
            wr_cnt     = 0;
            rd_cnt     = 0;
            rd_word    = 0;
            drop_total = '0;
            expected_words.delete();
        end else begin
            if (o_done) begin
                if (expected_words.size() == 0) begin
                    o_mismatch_count++;
                    if (o_mismatch_count <= SHOWN_MISMATCHES) begin
                        $error("result word with no request outstanding: data_word %h",
                               o_data_word);
                    end
                end else begin
                    want = expected_words.pop_front();
                    check_field("data_word", want.data_word, o_data_word);
                    check_field("word_valid", 32'(want.word_valid), 32'(o_word_valid));
                    check_field("last_word", 32'(want.last_word), 32'(o_last_word));
                    check_field("chunk_committed", 32'(want.committed),
                                32'(o_chunk_committed));
                    check_field("chunk_dropped", 32'(want.dropped), 32'(o_chunk_dropped));
                    check_field("ring_fill", 32'(want.ring_fill), 32'(o_ring_fill));
                    check_field("dropped_total", want.dropped_total, o_dropped_total);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                stream_on = i_cfg_data;
            end
            if (start && !busy) begin
                expected_words.push_back(next_packet_word(t_req_type'(i_req_type),
                                                          i_left_sample, i_right_sample));
            end
        end
        o_pending_words = expected_words.size();
    end

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the audio packetizer with push and pop requests: a short directed
// opening, then phases that fill and commit a chunk, read it out with the
// stream off and then on, and drain the ring to empty, under varying request gaps.
// ----------------------------------------------------------------------------
module testbench
    import cpr_pkg::*;
();

    localparam int WATCHDOG_CYCLES = 500_000;

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        start          = 1'b0;
    logic        busy;
    logic        i_req_type     = 1'b0;
    logic [15:0] i_left_sample  = '0;
    logic [15:0] i_right_sample = '0;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data     = 1'b0;
    logic        o_done;
    logic [31:0] o_data_word;
    logic        o_word_valid;
    logic        o_last_word;
    logic        o_chunk_committed;
    logic        o_chunk_dropped;
    logic [4:0]  o_ring_fill;
    logic [31:0] o_dropped_total;
    int          o_pending_words;
    int          o_mismatch_count;

    int push_words = 0;
    int pop_words  = 0;
    int phases     = 0;

    pcm_chunk_packetizer_ring_top DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_req_type        (i_req_type),
        .i_left_sample     (i_left_sample),
        .i_right_sample    (i_right_sample),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_done            (o_done),
        .o_data_word       (o_data_word),
        .o_word_valid      (o_word_valid),
        .o_last_word       (o_last_word),
        .o_chunk_committed (o_chunk_committed),
        .o_chunk_dropped   (o_chunk_dropped),
        .o_ring_fill       (o_ring_fill),
        .o_dropped_total   (o_dropped_total)
    );

    pcm_packet_checker u_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_req_type        (i_req_type),
        .i_left_sample     (i_left_sample),
        .i_right_sample    (i_right_sample),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_done            (o_done),
        .o_data_word       (o_data_word),
        .o_word_valid      (o_word_valid),
        .o_last_word       (o_last_word),
        .o_chunk_committed (o_chunk_committed),
        .o_chunk_dropped   (o_chunk_dropped),
        .o_ring_fill       (o_ring_fill),
        .o_dropped_total   (o_dropped_total),
        .o_pending_words   (o_pending_words),
        .o_mismatch_count  (o_mismatch_count)
    );

    // free-running clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // abort a hung run
    initial begin
        #(12 * WATCHDOG_CYCLES);
        $display("Test completed with failures");
        $finish;
    end

    // bias samples toward the range ends
    function automatic logic [15:0] pick_sample();
        logic [15:0] v;
        case ($urandom_range(7))
            0: v = 16'h8000;
            1: v = 16'h7FFF;
            2: v = 16'h0000;
            3: v = 16'hFFFF;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // Present one request word and hold it until it is taken.
    task automatic send_word(input t_req_type kind, input logic [15:0] left,
                             input logic [15:0] right);
        @(negedge i_clk);
        start          <= 1'b1;
        i_req_type     <= kind;
        i_left_sample  <= left;
        i_right_sample <= right;
        do @(posedge i_clk); while (busy);
        if (kind == REQ_PUSH) push_words++;
        else pop_words++;
    endtask

    // drop start for a number of cycles
    task automatic hold_off(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // Let the block go quiet, then write stream_enable.
    task automatic set_stream(input logic enable);
        hold_off(1);
        while (o_pending_words != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= enable;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One traffic phase: random pushes and pops with gaps and gap-free bursts.
    task automatic run_phase(input logic enable, input int idle_pct, input int words,
                             input int pop_pct);
        int        burst;
        int        n;
        t_req_type kind;
        burst = 0;
        set_stream(enable);
        for (n = 0; n < words; n++) begin
            kind = ($urandom_range(99) < pop_pct) ? REQ_POP : REQ_PUSH;
            send_word(kind, pick_sample(), pick_sample());
            if (burst > 0) burst--;
            else if ($urandom_range(99) < 3) burst = $urandom_range(40, 10);
            else if ($urandom_range(99) < idle_pct) hold_off($urandom_range(3, 1));
        end
        phases++;
    endtask

    initial begin
        int drain_cycles;

        // hold reset, then release it
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // pop on an empty ring, pushes ignored while the stream is off
        send_word(REQ_POP, 16'h0000, 16'h0000);
        send_word(REQ_PUSH, 16'h8000, 16'h7FFF);
        send_word(REQ_PUSH, 16'hFFFF, 16'h0000);
        send_word(REQ_POP, 16'hFFFF, 16'hFFFF);

        // field extremes into the first chunk, then pop while still empty
        set_stream(1'b1);
        send_word(REQ_PUSH, 16'h8000, 16'h7FFF);
        send_word(REQ_PUSH, 16'h7FFF, 16'h8000);
        send_word(REQ_PUSH, 16'h0000, 16'hFFFF);
        send_word(REQ_PUSH, 16'hFFFF, 16'h0000);
        send_word(REQ_PUSH, 16'h5555, 16'hAAAA);
        send_word(REQ_PUSH, 16'hAAAA, 16'h5555);
        send_word(REQ_PUSH, 16'h0001, 16'hFFFE);
        send_word(REQ_POP, 16'h0000, 16'h0000);

        // gap-free pushes until the first chunk commits
        run_phase(1'b1, 0, 510, 0);
        // stream off: pops keep draining, pushes are ignored
        run_phase(1'b0, 63, 220, 95);
        // read the packet out to its last word
        run_phase(1'b1, 31, 300, 97);
        // keep popping on the empty ring with the stream off
        run_phase(1'b0, 31, 30, 80);

        // wait out the last results
        hold_off(1);
        for (drain_cycles = 0; o_pending_words != 0 && drain_cycles < 200; drain_cycles++) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);

        $display("Ran %0d push and %0d pop words over %0d traffic phases plus a directed opening.",
                 push_words, pop_words, phases);
        $display("Ring overran %0d times; %0d mismatches, %0d results still outstanding.",
                 o_dropped_total, o_mismatch_count, o_pending_words);
        if (o_mismatch_count == 0 && o_pending_words == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* pcm_chunk_packetizer_ring_top.f */
hw/rtl/cpr_pkg.sv
hw/rtl/cpr_sample_mem.sv
hw/rtl/cpr_ring_ctrl.sv
hw/rtl/pcm_chunk_packetizer_ring_top.sv
bench/pcm_packet_checker.sv
bench/testbench.sv
